// ===== hw/rtl/fsp_pkg.sv =====
// Shared widths and command codes for the flag stack with population count.
`default_nettype none

package fsp_pkg;

    localparam int KIND_W = 3;
    localparam int POS_W  = 10;
    localparam int AMT_W  = 11;
    localparam int CNT_W  = 11;

    localparam logic [KIND_W-1:0] KIND_GROW   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SHRINK = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNT  = 3'd4;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_WALK   = 6'b001000,
        ST_TAIL   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/flag_stack_with_popcount.sv =====
// Top level: growable flag row with running set count, driven by a small sequencer.
`default_nettype none

// A request is taken only while the sequencer is idle; each request gives one result.
// Grow, count query and rejected requests go from EXEC straight to RESULT; set and
// clear pass through TAIL as well (one read-modify-write on the flag RAM plus a count
// update), and shrink by k runs k WALK steps before TAIL, since the walk clears one
// removed flag per cycle through the single port pair of the flag RAM. RESULT waits
// while the output register still holds an untaken result. The sequencer is ready
// again in the cycle the result appears. After reset the block sweeps the flag RAM to
// zero, one entry per cycle, before it takes the first request. A finished result
// waits in the output register while the next request is already taken. Length and
// count report their low 11 bits.
module flag_stack_with_popcount #(
    parameter int CAPACITY = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fsp_pkg::KIND_W-1:0] s_kind,
    input  logic [fsp_pkg::POS_W-1:0]  s_position,
    input  logic [fsp_pkg::AMT_W-1:0]  s_amount,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [fsp_pkg::CNT_W-1:0]  m_set_count,
    output logic [fsp_pkg::CNT_W-1:0]  m_row_length,
    output logic                       m_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int WW = (LW > fsp_pkg::AMT_W) ? LW : fsp_pkg::AMT_W;
    localparam logic [WW:0]   CAP_X     = (WW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

    fsp_pkg::state_t state_reg, state_next;

    logic [fsp_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [fsp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [fsp_pkg::AMT_W-1:0]  amt_reg, amt_next;
    logic [fsp_pkg::AMT_W-1:0]  remain_reg, remain_next;
    logic [LW-1:0]              length_reg, length_next;
    logic [LW-1:0]              count_reg, count_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic                       chk_reg, chk_next;
    logic                       chk_set_reg, chk_set_next;
    logic                       status_reg, status_next;
    logic                       m_valid_reg, m_valid_next;
    logic [fsp_pkg::CNT_W-1:0]  out_count_reg, out_count_next;
    logic [fsp_pkg::CNT_W-1:0]  out_length_reg, out_length_next;
    logic                       out_status_reg, out_status_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;

    logic [WW-1:0] len_w, pos_w, amt_w, cnt_w, shrink_diff;
    logic [WW:0]   grow_sum;
    logic          grow_bad, shrink_bad, pos_bad;

    fsp_ram #(
        .WIDTH(1),
        .DEPTH(CAPACITY)
    ) u_flags (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_addr),
        .wr_data(ram_wdata),
        .rd_addr(ram_addr),
        .rd_data(ram_rdata)
    );

    assign len_w       = WW'(length_reg);
    assign pos_w       = WW'(pos_reg);
    assign amt_w       = WW'(amt_reg);
    assign cnt_w       = WW'(count_reg);
    assign grow_sum    = {1'b0, len_w} + {1'b0, amt_w};
    assign shrink_diff = len_w - amt_w;
    assign grow_bad    = grow_sum > CAP_X;
    assign shrink_bad  = amt_w > len_w;
    assign pos_bad     = pos_w >= len_w;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        amt_next        = amt_reg;
        remain_next     = remain_reg;
        length_next     = length_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        clr_addr_next   = clr_addr_reg;
        chk_next        = 1'b0;
        chk_set_next    = chk_set_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg;
        out_count_next  = out_count_reg;
        out_length_next = out_length_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // fold in the old flag value read in the previous cycle
        if (chk_reg) begin
            if (chk_set_reg && !ram_rdata) begin
                count_next = count_reg + LW'(1);
            end else if (!chk_set_reg && ram_rdata) begin
                count_next = count_reg - LW'(1);
            end
        end

        unique case (state_reg)
            fsp_pkg::ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = fsp_pkg::ST_IDLE;
                end
            end
            fsp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    pos_next   = s_position;
                    amt_next   = s_amount;
                    state_next = fsp_pkg::ST_EXEC;
                end
            end
            fsp_pkg::ST_EXEC: begin
                status_next = 1'b0;
                state_next  = fsp_pkg::ST_RESULT;
                unique case (kind_reg) inside
                    fsp_pkg::KIND_GROW: begin
                        if (grow_bad) begin
                            status_next = 1'b1;
                        end else begin
                            length_next = grow_sum[LW-1:0];
                        end
                    end
                    fsp_pkg::KIND_SHRINK: begin
                        if (shrink_bad) begin
                            status_next = 1'b1;
                        end else begin
                            length_next = shrink_diff[LW-1:0];
                            if (amt_reg != '0) begin
                                idx_next    = length_reg[AW-1:0] - AW'(1);
                                remain_next = amt_reg;
                                state_next  = fsp_pkg::ST_WALK;
                            end
                        end
                    end
                    fsp_pkg::KIND_SET, fsp_pkg::KIND_CLEAR: begin
                        if (pos_bad) begin
                            status_next = 1'b1;
                        end else begin
                            ram_we       = 1'b1;
                            ram_addr     = pos_w[AW-1:0];
                            ram_wdata    = (kind_reg == fsp_pkg::KIND_SET);
                            chk_next     = 1'b1;
                            chk_set_next = (kind_reg == fsp_pkg::KIND_SET);
                            state_next   = fsp_pkg::ST_TAIL;
                        end
                    end
                    fsp_pkg::KIND_COUNT: begin
                    end
                    default: begin
                        status_next = 1'b1;
                    end
                endcase
            end
            fsp_pkg::ST_WALK: begin
                // clear the removed flag, check its old value next cycle
                ram_we       = 1'b1;
                ram_wdata    = 1'b0;
                chk_next     = 1'b1;
                chk_set_next = 1'b0;
                idx_next     = idx_reg - AW'(1);
                remain_next  = remain_reg - fsp_pkg::AMT_W'(1);
                if (remain_reg == fsp_pkg::AMT_W'(1)) begin
                    state_next = fsp_pkg::ST_TAIL;
                end
            end
            fsp_pkg::ST_TAIL: begin
                state_next = fsp_pkg::ST_RESULT;
            end
            fsp_pkg::ST_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_count_next  = cnt_w[fsp_pkg::CNT_W-1:0];
                    out_length_next = len_w[fsp_pkg::CNT_W-1:0];
                    out_status_next = status_reg;
                    state_next      = fsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fsp_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            chk_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            chk_reg      <= chk_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        amt_reg        <= amt_next;
        remain_reg     <= remain_next;
        idx_reg        <= idx_next;
        chk_set_reg    <= chk_set_next;
        status_reg     <= status_next;
        out_count_reg  <= out_count_next;
        out_length_reg <= out_length_next;
        out_status_reg <= out_status_next;
    end

    assign s_ready      = (state_reg == fsp_pkg::ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_set_count  = out_count_reg;
    assign m_row_length = out_length_reg;
    assign m_status     = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fsp_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read-first read per cycle.
`default_nettype none

module fsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
